@@ rtl/sne_pkg.sv @@
// shared types and constants for the sorting network evaluator
package sne_pkg;

    typedef enum logic [1:0] {
        ACT_CELL  = 2'd0,
        ACT_VALUE = 2'd1,
        ACT_RUN   = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    localparam logic CFG_ACTIVE_ROWS    = 1'b0;
    localparam logic CFG_ACTIVE_COLUMNS = 1'b1;

    localparam int ACTIVE_ROWS_RESET    = 16;
    localparam int ACTIVE_COLUMNS_RESET = 32;
    localparam int MIN_ROWS             = 2;

    localparam logic [4:0] LABEL_NONE  = 5'd0;
    localparam logic [4:0] LABEL_LIMIT = 5'd26;
    localparam int         PAIR_COUNT  = 2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHK_COL,
        S_CHK_ROW,
        S_ERR,
        S_RUN_COL,
        S_RUN_ROW,
        S_RUN_CMP,
        S_SWAP1,
        S_SWAP2,
        S_SORT_RD,
        S_SORT_CMP,
        S_OUT_RD,
        S_OUT
    } state_t;

    typedef struct packed {
        logic clear_we;
        logic cell_we;
        logic val_we;
        logic run_init;
        logic pick;
        logic cap;
        logic swap_wr_t;
        logic swap_wr_r;
        logic sel_sort;
        logic asc_clr;
        logic emit_ok;
        logic emit_err;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic row_bad;
        logic has_partner;
        logic greater;
    } status_t;

endpackage

@@ rtl/sne_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
module sne_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/sne_dp.sv @@
// datapath: label grid, row values, pair search, compare and result registers
module sne_dp
    import sne_pkg::*;
#(
    parameter int MAX_ROWS    = 16,
    parameter int MAX_COLUMNS = 32,
    parameter int VALUE_WIDTH = 32,
    parameter int ROW_W       = 4,
    parameter int COL_W       = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output status_t             status,
    input  logic [ROW_W-1:0]    row,
    input  logic [COL_W-1:0]    col,
    input  logic [ROW_W-1:0]    last_row,
    input  logic [3:0]          row_index,
    input  logic [4:0]          column_index,
    input  logic [4:0]          label,
    input  logic signed [31:0]  value,
    output logic                strobe,
    output logic signed [31:0]  out_value,
    output logic [3:0]          out_row,
    output logic                sorted,
    output logic                net_invalid,
    output logic                last
);

    logic                   row_in_range;
    logic                   col_in_range;
    logic [ROW_W-1:0]       wr_row;
    logic [COL_W-1:0]       wr_col;
    logic [4:0]             lab_rd [MAX_ROWS];
    logic [4:0]             labs_m [MAX_ROWS];
    logic [4:0]             lab;
    logic [MAX_ROWS-1:0]    match_vec;
    logic                   found;
    logic [ROW_W-1:0]       partner;
    logic [ROW_W-1:0]       partner_reg;
    logic [VALUE_WIDTH-1:0] a_rd;
    logic [VALUE_WIDTH-1:0] b_rd;
    logic [VALUE_WIDTH-1:0] a_hold_reg;
    logic [VALUE_WIDTH-1:0] b_hold_reg;
    logic                   v_we;
    logic [ROW_W-1:0]       v_waddr;
    logic [VALUE_WIDTH-1:0] v_wdata;
    logic [ROW_W-1:0]       b_raddr;
    logic                   asc_reg;
    logic                   strobe_reg;
    logic [31:0]            out_value_reg;
    logic [3:0]             out_row_reg;
    logic                   sorted_reg;
    logic                   invalid_reg;
    logic                   last_reg;

    assign row_in_range = (int'(row_index) < MAX_ROWS);
    assign col_in_range = (int'(column_index) < MAX_COLUMNS);
    assign wr_row       = ROW_W'(row_index);
    assign wr_col       = COL_W'(column_index);

    // one label ram per row, all read at the same column
    for (genvar g = 0; g < MAX_ROWS; g++)
    begin : g_row
        logic       l_we;
        logic [4:0] l_wdata;

        assign l_we    = cmd.clear_we
                       || (cmd.cell_we && row_in_range && col_in_range
                           && (wr_row == ROW_W'(g)));
        assign l_wdata = cmd.clear_we ? LABEL_NONE : label;

        sne_ram #(
            .WIDTH (5),
            .DEPTH (MAX_COLUMNS)
        ) u_lab_ram (
            .clk   (clk),
            .we    (l_we),
            .waddr (cmd.clear_we ? col : wr_col),
            .wdata (l_wdata),
            .raddr (col),
            .rdata (lab_rd[g])
        );

        // rows beyond the active count hold no comparator
        assign labs_m[g]    = (g <= int'(last_row)) ? lab_rd[g] : LABEL_NONE;
        assign match_vec[g] = (labs_m[g] == lab);
    end

    assign lab = labs_m[row];

    always_comb
    begin
        found   = 1'b0;
        partner = '0;
        for (int g = MAX_ROWS - 1; g >= 0; g--)
        begin
            if ((g > int'(row)) && match_vec[g] && (lab != LABEL_NONE))
            begin
                found   = 1'b1;
                partner = ROW_W'(g);
            end
        end
    end

    assign status.row_bad     = (lab > LABEL_LIMIT)
                              || ((lab != LABEL_NONE) && ($countones(match_vec) != PAIR_COUNT));
    assign status.has_partner = found;
    assign status.greater     = ($signed(a_rd) > $signed(b_rd));

    // row values, mirrored into two rams for two read addresses
    always_comb
    begin
        if (cmd.swap_wr_t)
        begin
            v_we    = 1'b1;
            v_waddr = partner_reg;
            v_wdata = a_hold_reg;
        end
        else if (cmd.swap_wr_r)
        begin
            v_we    = 1'b1;
            v_waddr = row;
            v_wdata = b_hold_reg;
        end
        else
        begin
            v_we    = cmd.val_we && row_in_range;
            v_waddr = wr_row;
            v_wdata = VALUE_WIDTH'(value);
        end
    end

    assign b_raddr = cmd.sel_sort ? ROW_W'(row + 1'b1) : partner;

    sne_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (MAX_ROWS)
    ) u_val_ram_a (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (row),
        .rdata (a_rd)
    );

    sne_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (MAX_ROWS)
    ) u_val_ram_b (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (b_raddr),
        .rdata (b_rd)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.pick)
        begin
            partner_reg <= partner;
        end
        if (cmd.cap)
        begin
            a_hold_reg <= a_rd;
            b_hold_reg <= b_rd;
        end
        if (cmd.emit_ok)
        begin
            out_value_reg <= 32'(a_rd);
            out_row_reg   <= 4'(row);
            sorted_reg    <= asc_reg;
            invalid_reg   <= 1'b0;
            last_reg      <= cmd.last;
        end
        else if (cmd.emit_err)
        begin
            out_value_reg <= '0;
            out_row_reg   <= '0;
            sorted_reg    <= 1'b0;
            invalid_reg   <= 1'b1;
            last_reg      <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
            asc_reg    <= 1'b1;
        end
        else
        begin
            strobe_reg <= cmd.emit_ok || cmd.emit_err;
            if (cmd.run_init)
            begin
                asc_reg <= 1'b1;
            end
            else if (cmd.asc_clr)
            begin
                asc_reg <= 1'b0;
            end
        end
    end

    assign strobe      = strobe_reg;
    assign out_value   = signed'(out_value_reg);
    assign out_row     = out_row_reg;
    assign sorted      = sorted_reg;
    assign net_invalid = invalid_reg;
    assign last        = last_reg;

endmodule

@@ rtl/sne_ctrl.sv @@
// controller: clearing pass, check, column walk, order check and report
module sne_ctrl
    import sne_pkg::*;
#(
    parameter int MAX_COLUMNS = 32,
    parameter int ROW_W       = 4,
    parameter int COL_W       = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       action,
    output logic             busy,
    input  logic [ROW_W-1:0] last_row,
    input  logic [COL_W-1:0] last_col,
    input  logic             cols_zero,
    input  status_t          status,
    output cmd_t             cmd,
    output logic [ROW_W-1:0] row,
    output logic [COL_W-1:0] col
);

    state_t           state_reg;
    state_t           state_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    state_t           adv_state;
    logic [ROW_W-1:0] adv_row;
    logic [COL_W-1:0] adv_col;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    // next step of the column walk once a row is done
    always_comb
    begin
        adv_state = S_RUN_ROW;
        adv_row   = row_reg + 1'b1;
        adv_col   = col_reg;
        if (row_reg == last_row)
        begin
            adv_row = '0;
            if (col_reg == last_col)
            begin
                adv_col   = '0;
                adv_state = S_SORT_RD;
            end
            else
            begin
                adv_col   = col_reg + 1'b1;
                adv_state = S_RUN_COL;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_we = 1'b1;
                if (col_reg == COL_W'(MAX_COLUMNS - 1))
                begin
                    col_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    case (action_t'(action))
                        ACT_CELL:  cmd.cell_we = 1'b1;
                        ACT_VALUE: cmd.val_we  = 1'b1;
                        ACT_RUN:
                        begin
                            cmd.run_init = 1'b1;
                            row_next     = '0;
                            col_next     = '0;
                            state_next   = cols_zero ? S_SORT_RD : S_CHK_COL;
                        end
                        default: ;
                    endcase
                end
            end
            S_CHK_COL:
            begin
                state_next = S_CHK_ROW;
            end
            S_CHK_ROW:
            begin
                if (status.row_bad)
                begin
                    row_next   = '0;
                    col_next   = '0;
                    state_next = S_ERR;
                end
                else if (row_reg == last_row)
                begin
                    row_next = '0;
                    if (col_reg == last_col)
                    begin
                        col_next   = '0;
                        state_next = S_RUN_COL;
                    end
                    else
                    begin
                        col_next   = col_reg + 1'b1;
                        state_next = S_CHK_COL;
                    end
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            S_ERR:
            begin
                cmd.emit_err = 1'b1;
                state_next   = S_IDLE;
            end
            S_RUN_COL:
            begin
                state_next = S_RUN_ROW;
            end
            S_RUN_ROW:
            begin
                cmd.pick = 1'b1;
                if (status.has_partner)
                begin
                    state_next = S_RUN_CMP;
                end
                else
                begin
                    state_next = adv_state;
                    row_next   = adv_row;
                    col_next   = adv_col;
                end
            end
            S_RUN_CMP:
            begin
                cmd.cap = 1'b1;
                if (status.greater)
                begin
                    state_next = S_SWAP1;
                end
                else
                begin
                    state_next = adv_state;
                    row_next   = adv_row;
                    col_next   = adv_col;
                end
            end
            S_SWAP1:
            begin
                cmd.swap_wr_t = 1'b1;
                state_next    = S_SWAP2;
            end
            S_SWAP2:
            begin
                cmd.swap_wr_r = 1'b1;
                state_next    = adv_state;
                row_next      = adv_row;
                col_next      = adv_col;
            end
            S_SORT_RD:
            begin
                cmd.sel_sort = 1'b1;
                state_next   = S_SORT_CMP;
            end
            S_SORT_CMP:
            begin
                cmd.sel_sort = 1'b1;
                cmd.asc_clr  = status.greater;
                if (ROW_W'(row_reg + 1'b1) == last_row)
                begin
                    row_next   = '0;
                    state_next = S_OUT_RD;
                end
                else
                begin
                    row_next   = row_reg + 1'b1;
                    state_next = S_SORT_RD;
                end
            end
            S_OUT_RD:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.emit_ok = 1'b1;
                cmd.last    = (row_reg == last_row);
                if (row_reg == last_row)
                begin
                    row_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    row_next   = row_reg + 1'b1;
                    state_next = S_OUT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign row  = row_reg;
    assign col  = col_reg;

    a_swap_pair: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SWAP2 |-> $past(state_reg) == S_SWAP1)
        else $error("second swap write without the first");

    a_swap_after_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SWAP1 |-> $past(state_reg) == S_RUN_CMP && $past(status.greater))
        else $error("swap without a greater upper value");

    a_report_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && row_reg == last_row) |=> state_reg == S_IDLE)
        else $error("report did not end on the last row");

    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit_ok && cmd.emit_err))
        else $error("error and row word in the same cycle");

endmodule

@@ rtl/sorting_network_evaluator.sv @@
// top level of the programmable comparator network evaluator
//
// channel   direction  handshake                      payload
// item      in         start && !busy                 action, row_index, column_index,
//                                                     label, value
// config    in         cfg_valid && cfg_ready         cfg_index, cfg_data
// result    out        strobe, one cycle per word     out_value, out_row, sorted,
//                                                     net_invalid, last
//
// cell and value writes leave busy low
// a run checks each column one row per cycle, then walks the columns the same way with a
// compare per comparator and two swap writes where the row's value is greater than its
// partner's, then checks the order of adjacent rows and reports each row in turn
// after reset a clearing pass over all MAX_COLUMNS columns keeps busy high; config is always taken
// result words cannot be held off by the receiver
module sorting_network_evaluator
    import sne_pkg::*;
#(
    parameter int MAX_ROWS    = 16,
    parameter int MAX_COLUMNS = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         action,
    input  logic [3:0]         row_index,
    input  logic [4:0]         column_index,
    input  logic [4:0]         label,
    input  logic signed [31:0] value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [5:0]         cfg_data,
    output logic               strobe,
    output logic signed [31:0] out_value,
    output logic [3:0]         out_row,
    output logic               sorted,
    output logic               net_invalid,
    output logic               last
);

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    logic [4:0]       active_rows_reg;
    logic [5:0]       active_columns_reg;
    logic [ROW_W-1:0] last_row;
    logic [COL_W-1:0] last_col;
    logic             cols_zero;
    cmd_t             cmd;
    status_t          status;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_rows_reg    <= 5'(ACTIVE_ROWS_RESET);
            active_columns_reg <= 6'(ACTIVE_COLUMNS_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ACTIVE_ROWS:    active_rows_reg    <= cfg_data[4:0];
                CFG_ACTIVE_COLUMNS: active_columns_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamp the counts into the grid
    always_comb
    begin
        if (int'(active_rows_reg) < MIN_ROWS)
        begin
            last_row = ROW_W'(MIN_ROWS - 1);
        end
        else if (int'(active_rows_reg) > MAX_ROWS)
        begin
            last_row = ROW_W'(MAX_ROWS - 1);
        end
        else
        begin
            last_row = ROW_W'(int'(active_rows_reg) - 1);
        end

        cols_zero = (active_columns_reg == '0);
        if (int'(active_columns_reg) > MAX_COLUMNS)
        begin
            last_col = COL_W'(MAX_COLUMNS - 1);
        end
        else
        begin
            last_col = COL_W'(int'(active_columns_reg) - 1);
        end
    end

    sne_ctrl #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .ROW_W       (ROW_W),
        .COL_W       (COL_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .action    (action),
        .busy      (busy),
        .last_row  (last_row),
        .last_col  (last_col),
        .cols_zero (cols_zero),
        .status    (status),
        .cmd       (cmd),
        .row       (row),
        .col       (col)
    );

    sne_dp #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .VALUE_WIDTH (VALUE_WIDTH),
        .ROW_W       (ROW_W),
        .COL_W       (COL_W)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .row          (row),
        .col          (col),
        .last_row     (last_row),
        .row_index    (row_index),
        .column_index (column_index),
        .label        (label),
        .value        (value),
        .strobe       (strobe),
        .out_value    (out_value),
        .out_row      (out_row),
        .sorted       (sorted),
        .net_invalid  (net_invalid),
        .last         (last)
    );

endmodule
